/* rtl/unique_id_circular_queue_core_assert.svh */
// Assertion macros used by the ticket queue core.
`ifndef UNIQUE_ID_CIRCULAR_QUEUE_CORE_ASSERT_SVH
`define UNIQUE_ID_CIRCULAR_QUEUE_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define UIDQ_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("ticket queue assertion failed");
`define UIDQ_ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("ticket queue forbidden condition seen");
`else
`define UIDQ_ASSERT(label, clk, rst, prop)
`define UIDQ_ASSERT_NEVER(label, clk, rst, cond)
`endif
`endif

/* rtl/uidq_pkg.sv */
// Types and constants of the ticket queue.
package uidq_pkg;

   localparam int FUNC_BITS     = 2;
   localparam int TICKET_BITS   = 16;
   localparam int STATUS_BITS   = 2;
   localparam int REQ_DATA_BITS = 24;
   localparam int RSP_DATA_BITS = 24;

   typedef enum logic [FUNC_BITS-1:0] {
      FUNC_JOIN  = 2'd0,
      FUNC_SERVE = 2'd1,
      FUNC_LIST  = 2'd2
   } func_type;

   typedef enum logic [STATUS_BITS-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_DUP   = 2'd2,
      STATUS_EMPTY = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_SCAN,
      BACK_SERVE,
      BACK_LIST
   } back_state_type;

   typedef struct packed {
      func_type               func;
      logic [TICKET_BITS-1:0] ticket_id;
   } cmd_type;

   typedef struct packed {
      status_type             status;
      logic [TICKET_BITS-1:0] out_id;
      logic                   last;
   } result_type;

endpackage

/* rtl/uidq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module uidq_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

/* rtl/uidq_front.sv */
// Request front end: accepts requests, drops unused codes, and queues commands.
module uidq_front (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [uidq_pkg::REQ_DATA_BITS-1:0]     req_tdata,
   output logic                                   cmd_valid,
   output uidq_pkg::cmd_type                      cmd,
   input  logic                                   cmd_pop
);
   import uidq_pkg::*;

   cmd_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   cmd_type    req_cmd;
   logic       known_func;
   logic       push;

   assign req_cmd.func      = func_type'(req_tdata[FUNC_BITS-1:0]);
   assign req_cmd.ticket_id = req_tdata[FUNC_BITS +: TICKET_BITS];
   assign known_func = (req_cmd.func == FUNC_JOIN) || (req_cmd.func == FUNC_SERVE) ||
                       (req_cmd.func == FUNC_LIST);

   assign req_tready = (count_ff != 2'd2);
   assign push       = req_tvalid && req_tready && known_func;
   assign cmd_valid  = (count_ff != 2'd0);
   assign cmd        = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, cmd_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= req_cmd;
      end
   end
endmodule

/* rtl/uidq_back.sv */
// Command back end: ring pointers, duplicate scan, serve and list sequencing.
module uidq_back #(
   parameter int SLOTS   = 8,
   parameter int ID_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   cmd_valid,
   input  uidq_pkg::cmd_type      cmd,
   output logic                   cmd_pop,
   output logic                   res_valid,
   output uidq_pkg::result_type   res,
   input  logic                   res_ready
);
   import uidq_pkg::*;

   localparam int PTR_BITS = $clog2(SLOTS);
   localparam logic [PTR_BITS-1:0] LAST_SLOT = PTR_BITS'(SLOTS - 1);

   back_state_type      state_ff, state_in;
   logic [PTR_BITS-1:0] head_ff, head_in;
   logic [PTR_BITS-1:0] tail_ff, tail_in;
   logic [PTR_BITS-1:0] scan_ff, scan_in;
   logic [ID_BITS-1:0]  key_ff, key_in;
   logic [PTR_BITS-1:0] head_next, tail_next, scan_next;
   logic                is_empty, is_full, scan_at_tail, key_match;
   logic [ID_BITS-1:0]  cmd_key;
   logic                wr_en, rd_en;
   logic [PTR_BITS-1:0] rd_addr;
   logic [ID_BITS-1:0]  wr_data, rd_data;

   assign head_next    = (head_ff == LAST_SLOT) ? '0 : head_ff + PTR_BITS'(1);
   assign tail_next    = (tail_ff == LAST_SLOT) ? '0 : tail_ff + PTR_BITS'(1);
   assign scan_next    = (scan_ff == LAST_SLOT) ? '0 : scan_ff + PTR_BITS'(1);
   assign is_empty     = (head_ff == tail_ff);
   assign is_full      = (tail_next == head_ff);
   assign scan_at_tail = (scan_ff == tail_ff);
   assign cmd_key      = ID_BITS'(cmd.ticket_id);
   assign key_match    = (rd_data == key_ff);

   uidq_ram #(
      .WIDTH (ID_BITS),
      .DEPTH (SLOTS)
   ) u_entries (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (tail_next),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BACK_IDLE: begin
            if (cmd_valid && res_ready && !is_empty) begin
               case (cmd.func)
                  FUNC_JOIN:  state_in = is_full ? BACK_IDLE : BACK_SCAN;
                  FUNC_SERVE: state_in = BACK_SERVE;
                  FUNC_LIST:  state_in = BACK_LIST;
                  default:    state_in = BACK_IDLE;
               endcase
            end
         end
         BACK_SCAN: begin
            if (res_ready && (key_match || scan_at_tail)) begin
               state_in = BACK_IDLE;
            end
         end
         BACK_SERVE: begin
            if (res_ready) begin
               state_in = BACK_IDLE;
            end
         end
         BACK_LIST: begin
            if (res_ready && scan_at_tail) begin
               state_in = BACK_IDLE;
            end
         end
         default: state_in = BACK_IDLE;
      endcase
   end

   always_comb begin
      cmd_pop   = 1'b0;
      res_valid = 1'b0;
      res       = '0;
      rd_en     = 1'b0;
      rd_addr   = scan_ff;
      wr_en     = 1'b0;
      wr_data   = key_ff;
      head_in   = head_ff;
      tail_in   = tail_ff;
      scan_in   = scan_ff;
      key_in    = key_ff;
      case (state_ff)
         BACK_IDLE: begin
            if (cmd_valid && res_ready) begin
               cmd_pop = 1'b1;
               case (cmd.func)
                  FUNC_JOIN: begin
                     if (is_full) begin
                        res_valid  = 1'b1;
                        res.status = STATUS_FULL;
                        res.last   = 1'b1;
                     end else if (is_empty) begin
                        wr_en      = 1'b1;
                        wr_data    = cmd_key;
                        tail_in    = tail_next;
                        res_valid  = 1'b1;
                        res.status = STATUS_OK;
                        res.last   = 1'b1;
                     end else begin
                        key_in  = cmd_key;
                        scan_in = head_next;
                        rd_en   = 1'b1;
                        rd_addr = head_next;
                     end
                  end
                  FUNC_SERVE, FUNC_LIST: begin
                     if (is_empty) begin
                        res_valid  = 1'b1;
                        res.status = STATUS_EMPTY;
                        res.last   = 1'b1;
                     end else begin
                        scan_in = head_next;
                        rd_en   = 1'b1;
                        rd_addr = head_next;
                     end
                  end
                  default: cmd_pop = 1'b1;
               endcase
            end
         end
         BACK_SCAN: begin
            if (res_ready) begin
               if (key_match) begin
                  res_valid  = 1'b1;
                  res.status = STATUS_DUP;
                  res.last   = 1'b1;
               end else if (scan_at_tail) begin
                  wr_en      = 1'b1;
                  tail_in    = tail_next;
                  res_valid  = 1'b1;
                  res.status = STATUS_OK;
                  res.last   = 1'b1;
               end else begin
                  scan_in = scan_next;
                  rd_en   = 1'b1;
                  rd_addr = scan_next;
               end
            end
         end
         BACK_SERVE: begin
            if (res_ready) begin
               head_in    = head_next;
               res_valid  = 1'b1;
               res.status = STATUS_OK;
               res.out_id = TICKET_BITS'(rd_data);
               res.last   = 1'b1;
            end
         end
         BACK_LIST: begin
            if (res_ready) begin
               res_valid  = 1'b1;
               res.status = STATUS_OK;
               res.out_id = TICKET_BITS'(rd_data);
               res.last   = scan_at_tail;
               if (!scan_at_tail) begin
                  scan_in = scan_next;
                  rd_en   = 1'b1;
                  rd_addr = scan_next;
               end
            end
         end
         default: res = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BACK_IDLE;
         head_ff  <= '0;
         tail_ff  <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff <= scan_in;
      key_ff  <= key_in;
   end
endmodule

/* rtl/unique_id_circular_queue_core.sv */
// Ticket queue core: a ring of waiting ids with duplicate rejection.
//
// Requests arrive on the req_ stream: func 0 joins ticket_id at the tail, func 1 serves
// the head, func 2 lists all waiting ids oldest first, func 3 is dropped without a
// response. Responses leave on the rsp_ stream with a status and an id, and rsp_tlast
// marks the final response of each request. At most SLOTS-1 ids wait at once.
// A two-entry command queue decouples request intake from execution, so requests are
// taken while a response waits in the output register.
// A join that finds the ring full or empty, and any request on an empty ring, passes
// the command queue and is answered straight into the output register. A serve first
// reads the oldest entry from the entry RAM. A join with waiting ids reads one stored
// entry per cycle through the entry RAM's single read port while the output is not
// stalled. A list emits one id per cycle while not stalled, after its first read.
// Reset clears the pointers, the command queue and the output valid flag; the ring is
// empty afterward and ready at once.
// When the receiver holds rsp_tready low, the response is held and execution pauses;
// the command queue then fills and req_tready falls.
module unique_id_circular_queue_core #(
   parameter int SLOTS   = 8,
   parameter int ID_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // func [1:0], ticket_id [17:2], zero pad [23:18]
   input  logic [uidq_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // status [1:0], out_id [17:2], zero pad [23:18]
   output logic [uidq_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   output logic                                rsp_tlast
);
   import uidq_pkg::*;

`include "unique_id_circular_queue_core_assert.svh"

   logic       cmd_valid, cmd_pop;
   cmd_type    cmd;
   logic       res_valid, res_ready;
   result_type res;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff;

   uidq_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd),
      .cmd_pop    (cmd_pop)
   );

   uidq_back #(
      .SLOTS   (SLOTS),
      .ID_BITS (ID_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .res_valid (res_valid),
      .res       (res),
      .res_ready (res_ready)
   );

   assign res_ready    = !rsp_valid_ff || rsp_tready;
   assign rsp_valid_in = res_valid || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid) begin
         rsp_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_BITS - STATUS_BITS - TICKET_BITS)'(0),
                        rsp_ff.out_id, rsp_ff.status};
   assign rsp_tlast  = rsp_ff.last;

   `UIDQ_ASSERT(a_res_into_free_slot, clock, reset, res_valid |-> res_ready)
   `UIDQ_ASSERT(a_pop_only_when_queued, clock, reset, cmd_pop |-> cmd_valid)
   `UIDQ_ASSERT_NEVER(a_no_bad_final, clock, reset,
      rsp_tvalid && (rsp_ff.status != STATUS_OK) && (!rsp_tlast || (rsp_ff.out_id != '0)))
endmodule
